// ===== rtl/afr_pkg.sv =====
package afr_pkg;

    localparam int AFR_MAX_FRAME  = 21;
    localparam int AFR_IDLE_LIMIT = 10;

    localparam int HDR_PLUS_SUM   = 5;
    localparam int SUM_POS_LIMIT  = 19;
    localparam int LEN_POS        = 3;
    localparam int LEN_TO_SUM_POS = 4;
    localparam int MIN_STORE      = SUM_POS_LIMIT + 1;
    localparam int SP_W           = 5;

    typedef enum logic {
        OPC_BYTE = 1'b0,
        OPC_TICK = 1'b1
    } t_opcode;

    localparam logic STS_GOOD   = 1'b0;
    localparam logic STS_REJECT = 1'b1;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
        logic       line_error;
    } t_in;

    typedef struct packed {
        logic            status;
        logic [7:0]      frame_byte;
        logic [SP_W-1:0] byte_index;
        logic            last;
    } t_out;

    typedef enum logic [1:0] {
        S_RX   = 2'd0,
        S_SUM  = 2'd1,
        S_EMIT = 2'd2,
        S_REJ  = 2'd3
    } t_afr_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic emit_mode;
        logic clr_ptr;
        logic load_rej;
    } t_dp_cmd;

    typedef struct packed {
        logic fin;
        logic len_bad;
        logic sum_done;
        logic sum_ok;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/afr_datapath.sv =====
module afr_datapath
    import afr_pkg::*;
#(
    parameter int MAX_FRAME  = AFR_MAX_FRAME,
    parameter int IDLE_LIMIT = AFR_IDLE_LIMIT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in_data,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_out_stall,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    localparam int STORE_DEPTH = (MAX_FRAME > MIN_STORE) ? MAX_FRAME : MIN_STORE;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int IDL_W       = $clog2(IDLE_LIMIT + 1);

    logic [7:0]       r_mem [STORE_DEPTH];
    logic [7:0]       r_addr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDL_W-1:0] r_idle, n_idle;
    logic [7:0]       r_len;
    logic [SP_W-1:0]  r_sum_pos;
    logic [SP_W-1:0]  r_ptr, n_ptr;
    logic             r_q_vld, n_q_vld;
    logic [SP_W-1:0]  r_q_idx;
    logic [7:0]       r_sum;
    logic [7:0]       r_rd_data;
    logic             r_out_vld, n_out_vld;
    t_out             r_out;

    logic             byte_acc;
    logic             tick_acc;
    logic             frame_open;
    logic [CNT_W-1:0] cnt_inc;
    logic [8:0]       frame_end;
    logic             fin;
    logic             wr_en;
    logic             out_free;
    logic             step_lim;
    logic             consume;
    logic             step_eff;
    logic             load_emit;
    logic             load_rej;
    logic             sum_acc;
    logic             sum_done;

    always_comb begin
        byte_acc   = i_cmd.accept && (i_in_data.opcode == OPC_BYTE) && !i_in_data.line_error;
        tick_acc   = i_cmd.accept && (i_in_data.opcode == OPC_TICK);
        frame_open = (r_count != '0);
        cnt_inc    = r_count + CNT_W'(1);
        frame_end  = 9'(HDR_PLUS_SUM) + {1'b0, r_len};
        fin        = byte_acc && frame_open && (9'(cnt_inc) >= 9'(HDR_PLUS_SUM))
                     && ((9'(cnt_inc) == frame_end) || (cnt_inc >= CNT_W'(MAX_FRAME)));
        wr_en      = byte_acc && (frame_open || (i_in_data.rx_byte == r_addr));
        out_free   = !r_out_vld || !i_out_stall;

        step_lim   = i_cmd.emit_mode ? (r_ptr < r_sum_pos) : (r_ptr <= r_sum_pos);
        consume    = i_cmd.emit_mode ? out_free : 1'b1;
        step_eff   = i_cmd.step && step_lim && (!r_q_vld || consume);
        load_emit  = i_cmd.step && i_cmd.emit_mode && r_q_vld && out_free;
        load_rej   = i_cmd.load_rej && out_free;
        sum_acc    = i_cmd.step && !i_cmd.emit_mode && r_q_vld && (r_q_idx != r_sum_pos);
        sum_done   = i_cmd.step && !i_cmd.emit_mode && r_q_vld && (r_q_idx == r_sum_pos);
    end

    always_comb begin
        n_idle = r_idle;
        if (tick_acc) begin
            if (r_idle == IDL_W'(IDLE_LIMIT - 1)) begin
                n_idle = IDL_W'(IDLE_LIMIT);
            end else if (r_idle != IDL_W'(IDLE_LIMIT)) begin
                n_idle = r_idle + IDL_W'(1);
            end
        end else if (i_cmd.accept) begin
            n_idle = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (tick_acc && (r_idle == IDL_W'(IDLE_LIMIT - 1))) begin
            n_count = '0;
        end else if (byte_acc) begin
            if (!frame_open) begin
                if (i_in_data.rx_byte == r_addr) begin
                    n_count = CNT_W'(1);
                end
            end else if (fin) begin
                n_count = '0;
            end else begin
                n_count = cnt_inc;
            end
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (fin || i_cmd.clr_ptr) begin
            n_ptr = '0;
        end else if (step_eff) begin
            n_ptr = r_ptr + SP_W'(1);
        end
        n_q_vld   = step_eff || (r_q_vld && !consume);
        n_out_vld = load_emit || load_rej || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IDX_W'(r_count)] <= i_in_data.rx_byte;
        end
        if (step_eff) begin
            r_rd_data <= r_mem[IDX_W'(r_ptr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_count   <= '0;
            r_idle    <= '0;
            r_ptr     <= '0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_addr <= i_cfg_wr_data;
            end
            r_count   <= n_count;
            r_idle    <= n_idle;
            r_ptr     <= n_ptr;
            r_q_vld   <= n_q_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_acc && (r_count == CNT_W'(LEN_POS))) begin
            r_len <= i_in_data.rx_byte;
        end
        if (fin) begin
            r_sum_pos <= SP_W'({1'b0, r_len} + 9'(LEN_TO_SUM_POS));
            r_sum     <= '0;
        end else if (sum_acc) begin
            r_sum <= r_sum + r_rd_data;
        end
        if (step_eff) begin
            r_q_idx <= r_ptr;
        end
        if (load_emit) begin
            r_out.status     <= STS_GOOD;
            r_out.frame_byte <= r_rd_data;
            r_out.byte_index <= r_q_idx;
            r_out.last       <= (r_q_idx == (r_sum_pos - SP_W'(1)));
        end else if (load_rej) begin
            r_out.status     <= STS_REJECT;
            r_out.frame_byte <= '0;
            r_out.byte_index <= '0;
            r_out.last       <= 1'b1;
        end
    end

    always_comb begin
        o_sts.fin       = fin;
        o_sts.len_bad   = ({1'b0, r_len} + 9'(LEN_TO_SUM_POS)) > 9'(SUM_POS_LIMIT);
        o_sts.sum_done  = sum_done;
        o_sts.sum_ok    = (r_rd_data == r_sum);
        o_sts.emit_last = load_emit && (r_q_idx == (r_sum_pos - SP_W'(1)));
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_q_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld |-> (r_q_idx <= r_sum_pos))
        else $error("store read beyond checksum position");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_FRAME))
        else $error("byte count reached frame limit");

    a_idle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle <= IDL_W'(IDLE_LIMIT))
        else $error("idle counter past limit");

    a_fin_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_q_vld)
        else $error("frame closed while a store walk is pending");

endmodule

// ===== rtl/afr_ctrl.sv =====
module afr_ctrl
    import afr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_afr_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RX: begin
                if (i_in_valid && i_sts.fin) begin
                    n_state = i_sts.len_bad ? S_REJ : S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.sum_done) begin
                    n_state = i_sts.sum_ok ? S_EMIT : S_REJ;
                end
            end
            S_EMIT: begin
                if (i_sts.emit_last) begin
                    n_state = S_RX;
                end
            end
            S_REJ: begin
                if (i_sts.out_free) begin
                    n_state = S_RX;
                end
            end
            default: n_state = S_RX;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_RX: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_SUM: begin
                o_cmd.step    = 1'b1;
                o_cmd.clr_ptr = i_sts.sum_done && i_sts.sum_ok;
            end
            S_EMIT: begin
                o_cmd.step      = 1'b1;
                o_cmd.emit_mode = 1'b1;
            end
            S_REJ: begin
                o_cmd.load_rej = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/addressed_frame_receiver_unit.sv =====
// An item that does not close a frame leaves the input free for the next one. A closing
// byte with a valid length starts a walk of the store for the checksum; a good frame is
// then walked again and emitted, one result per cycle while the output is not stalled.
// Throughput: one item per cycle; a closing byte holds input off until its frame is
// emitted or rejected (output stalls included); walks use the store's single read port.
// Reset (synchronous, active low) clears address, counters, state and output valid.
module addressed_frame_receiver_unit
    import afr_pkg::*;
#(
    parameter int MAX_FRAME  = AFR_MAX_FRAME,
    parameter int IDLE_LIMIT = AFR_IDLE_LIMIT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    afr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    afr_datapath #(
        .MAX_FRAME  (MAX_FRAME),
        .IDLE_LIMIT (IDLE_LIMIT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule
